[design/gvsp_pkg.sv]
`default_nettype none

package gvsp_pkg;

    // Command codes on the command field.
    localparam logic [2:0] CMD_PLAY     = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_STOP_ALL = 3'd2;
    localparam logic [2:0] CMD_RESET    = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    localparam logic [7:0]  FLT_EXP_ALL_ONES = 8'hFF;
    localparam logic [30:0] FLT_ONE_MAG      = 31'h3F80_0000;

    localparam int QUEUE_DEPTH = 2;

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        logic [2:0]  code;
        logic        args_ok;
        logic [6:0]  hidx;
        logic [31:0] hgen;
    } gvsp_cmd_t;

    // Generation advance that skips zero.
    function automatic logic [31:0] next_gen(input logic [31:0] g);
        logic [31:0] n;
        n = g + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

endpackage

`default_nettype wire

[design/gvsp_front.sv]
`default_nettype none

module gvsp_front
    import gvsp_pkg::*;
#(
    parameter int VOICE_SLOTS = 64
)(
    input  wire logic [2:0]  command,
    input  wire logic [31:0] event_id,
    input  wire logic [31:0] clip_id,
    input  wire logic [31:0] volume_bits,
    input  wire logic [31:0] pan_bits,
    input  wire logic [31:0] pos_x_bits,
    input  wire logic [31:0] pos_y_bits,
    input  wire logic [6:0]  handle_index,
    input  wire logic [31:0] handle_generation,
    output gvsp_cmd_t        cmd
);

    logic play_ok;
    logic handle_ok;
    logic all_finite;

    always_comb
    begin
        all_finite = (volume_bits[30:23] != FLT_EXP_ALL_ONES)
                  && (pan_bits[30:23]    != FLT_EXP_ALL_ONES)
                  && (pos_x_bits[30:23]  != FLT_EXP_ALL_ONES)
                  && (pos_y_bits[30:23]  != FLT_EXP_ALL_ONES);
        // Negative zero passes the volume check.
        play_ok = (event_id != 32'd0) && (clip_id != 32'd0) && all_finite
               && !(volume_bits[31] && (volume_bits[30:0] != 31'd0))
               && (pan_bits[30:0] <= FLT_ONE_MAG);
        handle_ok = (handle_index != 7'd0) && (handle_generation != 32'd0)
                 && (11'(handle_index) <= 11'(VOICE_SLOTS));

        cmd.code = command;
        cmd.hidx = handle_index;
        cmd.hgen = handle_generation;
        case (command)
            CMD_PLAY:  cmd.args_ok = play_ok;
            CMD_STOP:  cmd.args_ok = handle_ok;
            CMD_QUERY: cmd.args_ok = handle_ok;
            default:   cmd.args_ok = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[design/gvsp_queue.sv]
`default_nettype none

module gvsp_queue
    import gvsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire gvsp_cmd_t push_data,
    input  wire logic      pop,
    output gvsp_cmd_t      pop_data,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gvsp_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/gvsp_back.sv]
`default_nettype none

module gvsp_back
    import gvsp_pkg::*;
#(
    parameter int VOICE_SLOTS = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire gvsp_cmd_t   q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [6:0]       voice_index,
    output logic [31:0]      voice_generation,
    output logic [6:0]       live_count,
    output logic [31:0]      device_gen
);

    localparam int IDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W = $clog2(VOICE_SLOTS + 1);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t                  state_reg;
    gvsp_cmd_t               op_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic                    found_reg;
    logic [VOICE_SLOTS-1:0]  live_reg;
    logic [VOICE_SLOTS-1:0]  written_reg;
    logic [VOICE_SLOTS-1:0]  pend_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [31:0]             devgen_reg;
    logic                    out_valid_reg;
    logic                    ok_reg;
    logic [6:0]              vidx_reg;
    logic [31:0]             vgen_reg;

    logic [31:0]             gen_mem [VOICE_SLOTS];
    logic [31:0]             rdata_reg;

    logic [IDX_W-1:0]        free_idx;
    logic                    free_found;
    logic [10:0]             hslot_ext;
    logic [IDX_W-1:0]        addr;
    logic [31:0]             eff_gen;
    logic [31:0]             claim_gen;
    logic                    handle_hit;
    logic                    mem_we;
    logic [31:0]             mem_wdata;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = VOICE_SLOTS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
        hslot_ext = 11'(q_data.hidx) - 11'd1;
        addr      = (q_data.code == CMD_PLAY) ? free_idx : hslot_ext[IDX_W-1:0];

        // A pending advance is left by stop-all and reset and applied when read.
        if (!written_reg[slot_reg])
        begin
            eff_gen = 32'd0;
        end
        else if (pend_reg[slot_reg])
        begin
            eff_gen = next_gen(rdata_reg);
        end
        else
        begin
            eff_gen = rdata_reg;
        end
        claim_gen  = (eff_gen == 32'd0) ? 32'd1 : eff_gen;
        handle_hit = op_reg.args_ok && live_reg[slot_reg] && (eff_gen == op_reg.hgen);

        mem_we    = 1'b0;
        mem_wdata = claim_gen;
        if (state_reg == ST_EXEC)
        begin
            case (op_reg.code)
                CMD_PLAY:
                begin
                    mem_we = op_reg.args_ok && found_reg;
                end
                CMD_STOP:
                begin
                    mem_we    = handle_hit;
                    mem_wdata = next_gen(eff_gen);
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rdata_reg <= gen_mem[addr];
        end
        if (mem_we)
        begin
            gen_mem[slot_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            written_reg   <= '0;
            pend_reg      <= '0;
            count_reg     <= '0;
            devgen_reg    <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            vidx_reg      <= '0;
            vgen_reg      <= '0;
            op_reg        <= '0;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        op_reg    <= q_data;
                        slot_reg  <= addr;
                        found_reg <= free_found;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    ok_reg        <= 1'b0;
                    vidx_reg      <= '0;
                    vgen_reg      <= '0;
                    state_reg     <= ST_IDLE;
                    case (op_reg.code)
                        CMD_PLAY:
                        begin
                            if (op_reg.args_ok && found_reg)
                            begin
                                live_reg[slot_reg]    <= 1'b1;
                                written_reg[slot_reg] <= 1'b1;
                                pend_reg[slot_reg]    <= 1'b0;
                                count_reg             <= count_reg + CNT_W'(1);
                                ok_reg                <= 1'b1;
                                vidx_reg              <= 7'(slot_reg) + 7'd1;
                                vgen_reg              <= claim_gen;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (handle_hit)
                            begin
                                live_reg[slot_reg] <= 1'b0;
                                count_reg          <= count_reg - CNT_W'(1);
                                ok_reg             <= 1'b1;
                            end
                        end
                        CMD_STOP_ALL:
                        begin
                            pend_reg  <= pend_reg | live_reg;
                            live_reg  <= '0;
                            count_reg <= '0;
                            ok_reg    <= 1'b1;
                        end
                        CMD_RESET:
                        begin
                            pend_reg   <= pend_reg | live_reg;
                            live_reg   <= '0;
                            count_reg  <= '0;
                            devgen_reg <= next_gen(devgen_reg);
                            ok_reg     <= 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            ok_reg <= handle_hit;
                        end
                        default:
                        begin
                            ok_reg <= 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign ok               = ok_reg;
    assign voice_index      = vidx_reg;
    assign voice_generation = vgen_reg;
    assign live_count       = 7'(count_reg);
    assign device_gen       = devgen_reg;

endmodule

`default_nettype wire

[design/generational_voice_slot_pool_unit.sv]
`default_nettype none

// Channel   Handshake                 Beat contents
// -------   -----------------------   -------------------------------------------------
// input     in_valid / in_stall       command, ids, float bit patterns, handle
// output    out_valid / out_stall     ok, voice_index, voice_generation, live_count,
//                                     device_gen
//
// In the back end, each command is popped in ST_IDLE, which reads the slot's
// generation from the generation memory, and then runs in ST_EXEC, which updates
// the slot and forms the result beat. The generation memory has a single read port.
// Reset is asynchronous and active low; it frees every slot at once, with
// no clearing pass. A two-beat queue parts the front from the back, so
// input beats are still taken while a result beat waits on out_stall.
module generational_voice_slot_pool_unit
    import gvsp_pkg::*;
#(
    parameter int VOICE_SLOTS = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] event_id,
    input  wire logic [31:0] clip_id,
    input  wire logic [31:0] volume_bits,
    input  wire logic [31:0] pan_bits,
    input  wire logic [31:0] pos_x_bits,
    input  wire logic [31:0] pos_y_bits,
    input  wire logic [6:0]  handle_index,
    input  wire logic [31:0] handle_generation,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [6:0]       voice_index,
    output logic [31:0]      voice_generation,
    output logic [6:0]       live_count,
    output logic [31:0]      device_gen
);

    gvsp_cmd_t front_cmd;
    gvsp_cmd_t q_data;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;

    // The front checks the play arguments and the handle range, so the
    // back only has to deal with slot state.
    gvsp_front #(
        .VOICE_SLOTS (VOICE_SLOTS)
    ) u_front (
        .command           (command),
        .event_id          (event_id),
        .clip_id           (clip_id),
        .volume_bits       (volume_bits),
        .pan_bits          (pan_bits),
        .pos_x_bits        (pos_x_bits),
        .pos_y_bits        (pos_y_bits),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .cmd               (front_cmd)
    );

    assign in_stall = q_full;

    gvsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back holds the live, written and pending-advance bits for each
    // slot in flip-flops and the generations in a memory.
    gvsp_back #(
        .VOICE_SLOTS (VOICE_SLOTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .ok               (ok),
        .voice_index      (voice_index),
        .voice_generation (voice_generation),
        .live_count       (live_count),
        .device_gen       (device_gen)
    );

endmodule

`default_nettype wire

[dv/tb_generational_voice_slot_pool_unit.sv]
`default_nettype none

// Self-checking bench for the generational voice slot pool. A directed table of
// beats is walked first, followed by random traffic that is mostly well-formed
// plays, stops and queries built from handles the bench has seen returned.
module tb_generational_voice_slot_pool_unit;
    import gvsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 64;
    localparam int RANDOM_BEATS   = 760;
    localparam int WATCHDOG_LIMIT = 20000;

    // One command beat as presented on the input channel.
    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] ev;
        logic [31:0] clip;
        logic [31:0] vol;
        logic [31:0] pan;
        logic [31:0] px;
        logic [31:0] py;
        logic [6:0]  hidx;
        logic [31:0] hgen;
    } voice_cmd_t;

    // One result beat as it leaves the output channel.
    typedef struct packed {
        logic        ok;
        logic [6:0]  vidx;
        logic [31:0] vgen;
        logic [6:0]  live;
        logic [31:0] dgen;
    } voice_res_t;

    // A directed row: the beat, and where it is obvious, the result it must give.
    typedef struct {
        voice_cmd_t c;
        bit         fixed;
        voice_res_t r;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [31:0] event_id;
    logic [31:0] clip_id;
    logic [31:0] volume_bits;
    logic [31:0] pan_bits;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic [6:0]  handle_index;
    logic [31:0] handle_generation;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [6:0]  voice_index;
    logic [31:0] voice_generation;
    logic [6:0]  live_count;
    logic [31:0] device_gen;

    generational_voice_slot_pool_unit #(.VOICE_SLOTS(SLOTS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .event_id(event_id), .clip_id(clip_id),
        .volume_bits(volume_bits), .pan_bits(pan_bits),
        .pos_x_bits(pos_x_bits), .pos_y_bits(pos_y_bits),
        .handle_index(handle_index), .handle_generation(handle_generation),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .voice_index(voice_index), .voice_generation(voice_generation),
        .live_count(live_count), .device_gen(device_gen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The bench's own copy of the pool.
    bit          pool_live [SLOTS];
    logic [31:0] pool_gen  [SLOTS];
    logic [31:0] pool_dev_gen;

    voice_res_t  pending_results [$];
    logic [38:0] known_handles   [$];   // {index, generation} handed out by plays
    int          mismatches;
    int          results_seen;
    int          plays_granted;
    int          pool_full_hits;
    int          idle_cycles;

    function automatic logic [31:0] gen_after(input logic [31:0] g);
        logic [31:0] n;
        n = g + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

    function automatic bit float_finite(input logic [31:0] b);
        return b[30:23] != FLT_EXP_ALL_ONES;
    endfunction

    function automatic bit play_args_valid(input voice_cmd_t c);
        if (c.ev == 32'd0 || c.clip == 32'd0)
            return 1'b0;
        if (!float_finite(c.vol) || !float_finite(c.pan) ||
            !float_finite(c.px) || !float_finite(c.py))
            return 1'b0;
        // Negative zero is still zero and passes as a volume.
        if (c.vol[31] && c.vol[30:0] != 31'd0)
            return 1'b0;
        if (c.pan[30:0] > FLT_ONE_MAG)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic int handle_slot(input logic [6:0] idx, input logic [31:0] g);
        if (idx == 7'd0 || g == 32'd0 || idx > SLOTS)
            return -1;
        if (!pool_live[idx - 1] || pool_gen[idx - 1] != g)
            return -1;
        return idx - 1;
    endfunction

    function automatic void release_all_slots();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pool_live[i])
            begin
                pool_live[i] = 1'b0;
                pool_gen[i]  = gen_after(pool_gen[i]);
            end
        end
    endfunction

    // Applies one command to the bench's pool and returns the result it must give.
    function automatic voice_res_t pool_apply(input voice_cmd_t c);
        voice_res_t r;
        int         s;
        int         free_slot;
        r = '{ok: 1'b0, vidx: 7'd0, vgen: 32'd0, live: 7'd0, dgen: 32'd0};
        case (c.cmd)
            CMD_PLAY:
            begin
                if (play_args_valid(c))
                begin
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!pool_live[i])
                            free_slot = i;
                    if (free_slot < 0)
                        pool_full_hits++;
                    else
                    begin
                        if (pool_gen[free_slot] == 32'd0)
                            pool_gen[free_slot] = 32'd1;
                        pool_live[free_slot] = 1'b1;
                        r.ok   = 1'b1;
                        r.vidx = 7'(free_slot + 1);
                        r.vgen = pool_gen[free_slot];
                        known_handles.insert(known_handles.size(), {r.vidx, r.vgen});
                        plays_granted++;
                    end
                end
            end
            CMD_STOP:
            begin
                s = handle_slot(c.hidx, c.hgen);
                if (s >= 0)
                begin
                    pool_live[s] = 1'b0;
                    pool_gen[s]  = gen_after(pool_gen[s]);
                    r.ok = 1'b1;
                end
            end
            CMD_STOP_ALL:
            begin
                release_all_slots();
                r.ok = 1'b1;
            end
            CMD_RESET:
            begin
                release_all_slots();
                pool_dev_gen = gen_after(pool_dev_gen);
                r.ok = 1'b1;
            end
            CMD_QUERY:
                r.ok = (handle_slot(c.hidx, c.hgen) >= 0);
            default:
                r.ok = 1'b0;
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (pool_live[i])
                r.live++;
        r.dgen = pool_dev_gen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Random gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stall, and every accepted beat is checked.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                voice_res_t want;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected",
                                    32'(voice_index), 32'd0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", 32'(ok), 32'(want.ok));
                    if (voice_index !== want.vidx)
                        report_mismatch("voice_index", 32'(voice_index), 32'(want.vidx));
                    if (voice_generation !== want.vgen)
                        report_mismatch("voice_generation", voice_generation, want.vgen);
                    if (live_count !== want.live)
                        report_mismatch("live_count", 32'(live_count), 32'(want.live));
                    if (device_gen !== want.dgen)
                        report_mismatch("device_gen", device_gen, want.dgen);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("tb_generational_voice_slot_pool_unit NOT OK");
            $finish;
        end
    end

    // Presents one beat and holds it until the block takes it.
    task automatic send_beat(input voice_cmd_t c, input bit fixed, input voice_res_t r);
        voice_res_t want;
        command           <= c.cmd;
        event_id          <= c.ev;
        clip_id           <= c.clip;
        volume_bits       <= c.vol;
        pan_bits          <= c.pan;
        pos_x_bits        <= c.px;
        pos_y_bits        <= c.py;
        handle_index      <= c.hidx;
        handle_generation <= c.hgen;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Predicting at acceptance keeps the bench's pool in step with the block's.
        want = pool_apply(c);
        if (fixed)
        begin
            if (want != r)
                report_mismatch("table row against the pool copy", want.vgen, r.vgen);
            want = r;
        end
        pending_results.insert(pending_results.size(), want);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic voice_cmd_t good_play();
        voice_cmd_t c;
        c.cmd  = CMD_PLAY;
        c.ev   = $urandom_range(1, 32'hFFFF_FFFF);
        c.clip = $urandom_range(1, 32'hFFFF_FFFF);
        c.vol  = {1'b0, 8'($urandom_range(0, 8'hFE)), 23'($urandom)};
        c.pan  = {1'($urandom), 31'($urandom_range(0, 32'h3F80_0000))};
        c.px   = $urandom;
        c.py   = $urandom;
        if (c.px[30:23] == 8'hFF) c.px[30] = 1'b0;
        if (c.py[30:23] == 8'hFF) c.py[30] = 1'b0;
        c.hidx = 7'($urandom);
        c.hgen = $urandom;
        return c;
    endfunction

    function automatic voice_cmd_t random_beat();
        voice_cmd_t c;
        int         p;
        logic [38:0] h;
        c = good_play();
        p = $urandom_range(0, 99);
        if (p < 40)
            ;
        else if (p < 50)
        begin
            // Broken play: one field disturbed, mostly knocked out of its legal range.
            case ($urandom_range(0, 5))
                0: c.ev = 32'd0;
                1: c.clip = 32'd0;
                2: c.vol[31] = 1'b1;
                3: c.pan[30:0] = 31'($urandom_range(32'h3F80_0001, 32'h7FFF_FFFF));
                4: c.px[30:23] = 8'hFF;
                default: c.py = $urandom;
            endcase
        end
        else if (p < 85 && known_handles.size() > 0)
        begin
            // Stop or query with a handle once handed out; it may be stale.
            h = known_handles[$urandom_range(0, known_handles.size() - 1)];
            c.cmd  = ($urandom_range(0, 1) == 0) ? CMD_STOP : CMD_QUERY;
            c.hidx = h[38:32];
            c.hgen = h[31:0];
            if ($urandom_range(0, 9) == 0)
                c.hgen = c.hgen + 32'd1;
        end
        else if (p < 89)
            c.cmd = CMD_STOP_ALL;
        else if (p < 92)
            c.cmd = CMD_RESET;
        else
            c.cmd = 3'($urandom_range(1, 7));
        return c;
    endfunction

    function automatic voice_cmd_t row_cmd(input logic [2:0] cmd, input logic [31:0] vol,
                                           input logic [31:0] pan, input int hidx,
                                           input logic [31:0] hgen);
        voice_cmd_t c;
        c = '{cmd: cmd, ev: 32'd1, clip: 32'hFFFF_FFFF, vol: vol, pan: pan,
              px: 32'h0000_0000, py: 32'hFF7F_FFFF, hidx: 7'(hidx), hgen: hgen};
        return c;
    endfunction

    function automatic voice_res_t res(input int k, input int vi,
                                       input logic [31:0] vg, input int lc,
                                       input logic [31:0] dg);
        voice_res_t r;
        r = '{ok: 1'(k), vidx: 7'(vi), vgen: vg, live: 7'(lc), dgen: dg};
        return r;
    endfunction

    table_row_t directed [$];
    voice_res_t none_r;

    function automatic void add_row(input voice_cmd_t c, input bit fixed,
                                    input voice_res_t r);
        table_row_t row;
        row.c     = c;
        row.fixed = fixed;
        row.r     = r;
        directed.insert(directed.size(), row);
    endfunction

    initial
    begin
        voice_cmd_t c;
        int         guard;

        for (int i = 0; i < SLOTS; i++)
        begin
            pool_live[i] = 1'b0;
            pool_gen[i]  = 32'd0;
        end
        pool_dev_gen      = 32'd0;
        mismatches        = 0;
        results_seen      = 0;
        plays_granted     = 0;
        pool_full_hits    = 0;
        idle_cycles       = 0;
        none_r            = res(0, 0, 0, 0, 0);

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        command           = CMD_QUERY;
        event_id          = 32'd0;
        clip_id           = 32'd0;
        volume_bits       = 32'd0;
        pan_bits          = 32'd0;
        pos_x_bits        = 32'd0;
        pos_y_bits        = 32'd0;
        handle_index      = 7'd0;
        handle_generation = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows. Fixed results are the ones that follow straight from reset.
        add_row(row_cmd(CMD_QUERY, 0, 0, 0, 32'd0), 1'b1, none_r);
        add_row(row_cmd(CMD_STOP, 0, 0, 64, 32'hFFFF_FFFF), 1'b1, none_r);
        add_row(row_cmd(CMD_QUERY, 0, 0, 127, 32'd1), 1'b1, none_r);
        // Negative zero volume and pan at exactly minus one both pass.
        add_row(row_cmd(CMD_PLAY, 32'h8000_0000, 32'hBF80_0000, 0, 0),
                1'b1, res(1, 1, 1, 1, 0));
        add_row(row_cmd(CMD_PLAY, 32'h7F7F_FFFF, 32'h3F80_0000, 0, 0),
                1'b1, res(1, 2, 1, 2, 0));
        // Rejected plays: pan just past one, negative volume, infinity, NaN, zero ids.
        add_row(row_cmd(CMD_PLAY, 0, 32'h3F80_0001, 0, 0), 1'b1, res(0, 0, 0, 2, 0));
        add_row(row_cmd(CMD_PLAY, 32'h8000_0001, 0, 0, 0), 1'b1, res(0, 0, 0, 2, 0));
        add_row(row_cmd(CMD_PLAY, 32'h7F80_0000, 0, 0, 0), 1'b1, res(0, 0, 0, 2, 0));
        add_row(row_cmd(CMD_PLAY, 0, 32'hFFFF_FFFF, 0, 0), 1'b1, res(0, 0, 0, 2, 0));
        c = row_cmd(CMD_PLAY, 0, 0, 0, 0);
        c.ev = 32'd0;
        add_row(c, 1'b1, res(0, 0, 0, 2, 0));
        c = row_cmd(CMD_PLAY, 0, 0, 0, 0);
        c.clip = 32'd0;
        c.px   = 32'h7FC0_0000;
        add_row(c, 1'b1, res(0, 0, 0, 2, 0));
        add_row(row_cmd(CMD_QUERY, 0, 0, 1, 32'd1), 1'b1, res(1, 0, 0, 2, 0));
        add_row(row_cmd(CMD_QUERY, 0, 0, 1, 32'd2), 1'b1, res(0, 0, 0, 2, 0));
        add_row(row_cmd(CMD_STOP, 0, 0, 1, 32'd1), 1'b1, res(1, 0, 0, 1, 0));
        add_row(row_cmd(CMD_STOP, 0, 0, 1, 32'd1), 1'b1, res(0, 0, 0, 1, 0));
        // The freed slot comes back with its generation moved on.
        add_row(row_cmd(CMD_PLAY, 0, 0, 0, 0), 1'b1, res(1, 1, 2, 2, 0));
        add_row(row_cmd(CMD_STOP_ALL, 0, 0, 0, 0), 1'b1, res(1, 0, 0, 0, 0));
        add_row(row_cmd(CMD_RESET, 0, 0, 0, 0), 1'b1, res(1, 0, 0, 0, 1));
        add_row(row_cmd(3'd5, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 1));
        add_row(row_cmd(3'd6, 0, 0, 1, 32'd3), 1'b1, res(0, 0, 0, 0, 1));
        add_row(row_cmd(3'd7, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 1));
        add_row(row_cmd(CMD_PLAY, 0, 0, 0, 0), 1'b1, res(1, 1, 3, 1, 1));

        foreach (directed[i])
        begin
            send_beat(directed[i].c, directed[i].fixed, directed[i].r);
            idle_gap(pick_gap());
        end

        // Fill the pool past its size so the full case is hit, unchecked by hand.
        for (int i = 0; i < SLOTS + 3; i++)
        begin
            send_beat(good_play(), 0, none_r);
            idle_gap((i % 9 == 0) ? pick_gap() : 0);
        end

        // Hold the sender until the block has drained every result.
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            c = random_beat();
            send_beat(c, 0, none_r);
            // Stretches with no idling at all alternate with gappy ones.
            if ((n / 100) % 2 == 1)
                idle_gap(pick_gap());
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d results: %0d plays granted, %0d plays refused for a full pool",
                 results_seen, plays_granted, pool_full_hits);
        $display("commands covered: play, stop, stop all, reset, query and unused codes");
        if (mismatches == 0)
            $display("tb_generational_voice_slot_pool_unit OK");
        else
            $display("tb_generational_voice_slot_pool_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
